### rtl/core/mmapc_pkg.sv
`default_nettype none
package mmapc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int VOLT_W = 16;
   localparam int ROUND_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DEF_SAMPLES_PER_ROUND = 8;
   localparam int DEF_WINDOW_LENGTH = 8;

   // reset thresholds in 1/16 mV: 3000 mV, 10 mV, 2500 mV, 100 mV
   localparam logic [CSR_DATA_W-1:0] RESET_OPEN_THRESHOLD = 16'd48000;
   localparam logic [CSR_DATA_W-1:0] RESET_SHORT_THRESHOLD = 16'd160;
   localparam logic [CSR_DATA_W-1:0] RESET_VALID_MAX = 16'd40000;
   localparam logic [CSR_DATA_W-1:0] RESET_VALID_MIN = 16'd1600;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OPEN_THRESHOLD = 2'd0,
      CSR_SHORT_THRESHOLD = 2'd1,
      CSR_VALID_MAX = 2'd2,
      CSR_VALID_MIN = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PROBE_OK = 2'd0,
      PROBE_OPEN = 2'd1,
      PROBE_SHORT = 2'd2,
      PROBE_OUT_OF_RANGE = 2'd3
   } probe_state_type;

   typedef struct packed {
      logic sample_load;
      logic window_read;
      logic window_update;
      logic result_load;
   } dp_cmd_type;

   typedef struct packed {
      logic round_last;
      logic div_busy;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/core/mmapc_chan_if.sv
`default_nettype none
interface mmapc_req_if;
   logic valid;
   logic ready;
   logic [mmapc_pkg::SAMPLE_W-1:0] sample_voltage;

   modport source (output valid, output sample_voltage, input ready);
   modport sink (input valid, input sample_voltage, output ready);
endinterface

interface mmapc_rsp_if;
   logic valid;
   logic ready;
   logic [mmapc_pkg::VOLT_W-1:0] mean_voltage;
   logic [1:0] probe_state;
   logic [mmapc_pkg::ROUND_W-1:0] round_number;

   modport source (output valid, output mean_voltage, output probe_state,
                   output round_number, input ready);
   modport sink (input valid, input mean_voltage, input probe_state,
                 input round_number, output ready);
endinterface
`default_nettype wire

### rtl/core/mmapc_ctrl.sv
`default_nettype none
module mmapc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output mmapc_pkg::dp_cmd_type        dp_cmd,
   input  wire mmapc_pkg::dp_status_type dp_status
);

   typedef enum logic [2:0] {
      S_COLLECT,
      S_READ,
      S_UPDATE,
      S_DIVIDE,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      dp_cmd = '0;
      dp_cmd.sample_load = (state_ff == S_COLLECT) && req_valid;
      dp_cmd.window_read = (state_ff == S_READ);
      dp_cmd.window_update = (state_ff == S_UPDATE);
      dp_cmd.result_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_COLLECT: begin
            if (req_valid && dp_status.round_last) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (!dp_status.div_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold the result until the output register is free
            if (dp_cmd.result_load) begin
               rsp_valid_in = 1'b1;
               state_in = S_COLLECT;
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_COLLECT);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/core/mmapc_dp.sv
`default_nettype none
module mmapc_dp #(
   parameter int SAMPLES_PER_ROUND = mmapc_pkg::DEF_SAMPLES_PER_ROUND,
   parameter int WINDOW_LENGTH = mmapc_pkg::DEF_WINDOW_LENGTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [mmapc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [mmapc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [mmapc_pkg::SAMPLE_W-1:0]        sample_voltage,
   input  wire mmapc_pkg::dp_cmd_type                 dp_cmd,
   output mmapc_pkg::dp_status_type                   dp_status,
   output logic [mmapc_pkg::VOLT_W-1:0]               mean_voltage,
   output logic [1:0]                                 probe_state,
   output logic [mmapc_pkg::ROUND_W-1:0]              round_number
);

   localparam int SW = mmapc_pkg::SAMPLE_W;
   localparam int VW = mmapc_pkg::VOLT_W;
   localparam int FW = (SAMPLES_PER_ROUND > 1) ? $clog2(SAMPLES_PER_ROUND) : 1;
   localparam int MID = SAMPLES_PER_ROUND / 2;
   localparam int PW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int LW = $clog2(WINDOW_LENGTH + 1);
   localparam int TW = SW + LW;
   localparam int CW = $clog2(TW + 1);

   // thresholds
   logic [VW-1:0] open_thr_ff, short_thr_ff, vmax_ff, vmin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_thr_ff <= mmapc_pkg::RESET_OPEN_THRESHOLD;
         short_thr_ff <= mmapc_pkg::RESET_SHORT_THRESHOLD;
         vmax_ff <= mmapc_pkg::RESET_VALID_MAX;
         vmin_ff <= mmapc_pkg::RESET_VALID_MIN;
      end else if (csr_we) begin
         case (csr_index)
            mmapc_pkg::CSR_OPEN_THRESHOLD: open_thr_ff <= csr_wdata;
            mmapc_pkg::CSR_SHORT_THRESHOLD: short_thr_ff <= csr_wdata;
            mmapc_pkg::CSR_VALID_MAX: vmax_ff <= csr_wdata;
            mmapc_pkg::CSR_VALID_MIN: vmin_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // round store, kept sorted by inserting each sample in place
   logic [SW-1:0] round_ff [SAMPLES_PER_ROUND];
   logic [FW-1:0] round_fill_ff;
   logic [SAMPLES_PER_ROUND-1:0] greater;
   logic [SAMPLES_PER_ROUND-1:0] prev_greater;

   genvar gk;
   generate
      for (gk = 0; gk < SAMPLES_PER_ROUND; gk++) begin : g_cmp
         assign greater[gk] = (gk < int'(round_fill_ff)) && (round_ff[gk] > sample_voltage);
         if (gk == 0) begin : g_first
            assign prev_greater[gk] = 1'b0;
         end else begin : g_rest
            assign prev_greater[gk] = greater[gk-1];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (dp_cmd.sample_load) begin
         for (int k = 0; k < SAMPLES_PER_ROUND; k++) begin
            if (k <= int'(round_fill_ff)) begin
               if (prev_greater[k]) begin
                  round_ff[k] <= round_ff[(k == 0) ? 0 : k - 1];
               end else if (greater[k] || (k == int'(round_fill_ff))) begin
                  round_ff[k] <= sample_voltage;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_fill_ff <= '0;
      end else if (dp_cmd.sample_load) begin
         if (int'(round_fill_ff) == SAMPLES_PER_ROUND - 1) begin
            round_fill_ff <= '0;
         end else begin
            round_fill_ff <= round_fill_ff + 1'b1;
         end
      end
   end

   logic [SW-1:0] median;
   assign median = round_ff[MID];

   // window memory; the evicted median counts as zero until the window is full
   logic [SW-1:0] win_mem [WINDOW_LENGTH];
   logic [SW-1:0] win_rd_ff;
   logic [PW-1:0] win_ptr_ff;
   logic [LW-1:0] win_fill_ff, win_fill_in;
   logic [TW-1:0] win_total_ff, win_total_in;
   logic [SW-1:0] old_median;

   always_ff @(posedge clock) begin
      if (dp_cmd.window_update) begin
         win_mem[win_ptr_ff] <= median;
      end
      if (dp_cmd.window_read) begin
         win_rd_ff <= win_mem[win_ptr_ff];
      end
   end

   always_comb begin
      old_median = (win_fill_ff == LW'(WINDOW_LENGTH)) ? win_rd_ff : '0;
      win_total_in = win_total_ff - TW'(old_median) + TW'(median);
      win_fill_in = (win_fill_ff == LW'(WINDOW_LENGTH)) ? win_fill_ff : win_fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ptr_ff <= '0;
         win_fill_ff <= '0;
         win_total_ff <= '0;
      end else if (dp_cmd.window_update) begin
         win_total_ff <= win_total_in;
         win_fill_ff <= win_fill_in;
         if (int'(win_ptr_ff) == WINDOW_LENGTH - 1) begin
            win_ptr_ff <= '0;
         end else begin
            win_ptr_ff <= win_ptr_ff + 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [TW-1:0] quo_ff;
   logic [LW-1:0] rem_ff, divisor_ff;
   logic [CW-1:0] div_cnt_ff;
   logic [LW:0] trial;
   logic trial_ge;

   always_comb begin
      trial = {rem_ff, quo_ff[TW-1]};
      trial_ge = (trial >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.window_update) begin
         quo_ff <= win_total_in;
         rem_ff <= '0;
         divisor_ff <= win_fill_in;
      end else if (div_cnt_ff != '0) begin
         quo_ff <= {quo_ff[TW-2:0], trial_ge};
         rem_ff <= trial_ge ? LW'(trial - {1'b0, divisor_ff}) : trial[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (dp_cmd.window_update) begin
         div_cnt_ff <= CW'(TW);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   // classify: open first, then short, then range
   logic [VW-1:0] avg;
   mmapc_pkg::probe_state_type class_in;

   always_comb begin
      avg = quo_ff[VW-1:0];
      if (avg > open_thr_ff) begin
         class_in = mmapc_pkg::PROBE_OPEN;
      end else if (avg < short_thr_ff) begin
         class_in = mmapc_pkg::PROBE_SHORT;
      end else if ((avg > vmax_ff) || (avg < vmin_ff)) begin
         class_in = mmapc_pkg::PROBE_OUT_OF_RANGE;
      end else begin
         class_in = mmapc_pkg::PROBE_OK;
      end
   end

   logic [VW-1:0] volt_ff;
   mmapc_pkg::probe_state_type state_ff;
   logic [mmapc_pkg::ROUND_W-1:0] round_num_ff;
   logic [mmapc_pkg::ROUND_W-1:0] rounds_done_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.result_load) begin
         volt_ff <= avg;
         state_ff <= class_in;
         round_num_ff <= rounds_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_done_ff <= '0;
      end else if (dp_cmd.result_load) begin
         rounds_done_ff <= rounds_done_ff + 1'b1;
      end
   end

   always_comb begin
      dp_status = '0;
      dp_status.round_last = (int'(round_fill_ff) == SAMPLES_PER_ROUND - 1);
      dp_status.div_busy = (div_cnt_ff != '0);
   end

   assign mean_voltage = volt_ff;
   assign probe_state = state_ff;
   assign round_number = round_num_ff;

endmodule
`default_nettype wire

### rtl/core/median_moving_average_probe_check.sv
`default_nettype none
// Probe voltage filter: collects SAMPLES_PER_ROUND samples (1/16 mV units)
// into a round, takes the upper median of the round, averages the medians
// of the last WINDOW_LENGTH rounds (divided by the rounds seen so far,
// truncated) and classifies the average as ok, open, short or out of range
// against four thresholds written through the csr port (indexes 0 to 3:
// open, short, valid max, valid min). One response transaction per round.
// Samples are taken back to back while a round is collected, and each is
// inserted in sorted position on arrival. After the last sample of a round
// the block reads the window memory, updates the window sum, runs the
// bit-serial divider and loads the output register, in that order. Samples
// are refused in that time; the load, and the refusal with it, is held
// while a previous result still waits in the output register.
module median_moving_average_probe_check #(
   parameter int SAMPLES_PER_ROUND = mmapc_pkg::DEF_SAMPLES_PER_ROUND,
   parameter int WINDOW_LENGTH = mmapc_pkg::DEF_WINDOW_LENGTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mmapc_req_if.sink                              req_chan,
   mmapc_rsp_if.source                            rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [mmapc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mmapc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mmapc_pkg::dp_cmd_type dp_cmd;
   mmapc_pkg::dp_status_type dp_status;

   mmapc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   mmapc_dp #(
      .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND),
      .WINDOW_LENGTH     (WINDOW_LENGTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .sample_voltage   (req_chan.sample_voltage),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .mean_voltage     (rsp_chan.mean_voltage),
      .probe_state      (rsp_chan.probe_state),
      .round_number     (rsp_chan.round_number)
   );

endmodule
`default_nettype wire

### rtl/core/mmapc_check.sv
`default_nettype none
module mmapc_check (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [mmapc_pkg::VOLT_W-1:0]      mean_voltage,
   input wire logic [1:0]                        probe_state,
   input wire logic [mmapc_pkg::ROUND_W-1:0]     round_number
);

   logic [mmapc_pkg::ROUND_W-1:0] exp_round_ff;

   // count delivered transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_round_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_round_ff <= exp_round_ff + 1'b1;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(mean_voltage)
         && $stable(probe_state) && $stable(round_number)))
      else $error("stalled response changed");

   a_round_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (round_number == exp_round_ff))
      else $error("round number out of sequence");

   a_open_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (probe_state == mmapc_pkg::PROBE_OPEN)) |-> (mean_voltage != '0))
      else $error("open reported for zero average");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while sample taken");

endmodule

bind median_moving_average_probe_check mmapc_check u_mmapc_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .mean_voltage     (rsp_chan.mean_voltage),
   .probe_state      (rsp_chan.probe_state),
   .round_number     (rsp_chan.round_number)
);
`default_nettype wire

### test/probe_report_checker.sv
module probe_report_checker import mmapc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   mmapc_req_if                        req_mon,
   mmapc_rsp_if                        rsp_mon,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                 mismatches,
   output int unsigned                 reports_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROUND_LEN = DEF_SAMPLES_PER_ROUND;
   localparam int WIN_LEN = DEF_WINDOW_LENGTH;

   typedef struct packed {
      logic [VOLT_W-1:0]  mean_voltage;
      probe_state_type    probe_state;
      logic [ROUND_W-1:0] round_number;
   } probe_report_t;

   probe_report_t expected_reports[$];

   logic [CSR_DATA_W-1:0] open_lvl, short_lvl, max_lvl, min_lvl;

   logic [SAMPLE_W-1:0] round_buf [ROUND_LEN];
   int unsigned         round_count;
   logic [VOLT_W-1:0]   window_medians [WIN_LEN];
   int unsigned         win_slot;
   int unsigned         win_count;
   logic [18:0]         win_total;
   logic [ROUND_W-1:0]  rounds_reported;

   initial begin
      mismatches = 0;
      reports_pending = 0;
   end

   task automatic clear_filter();
      open_lvl = RESET_OPEN_THRESHOLD;
      short_lvl = RESET_SHORT_THRESHOLD;
      max_lvl = RESET_VALID_MAX;
      min_lvl = RESET_VALID_MIN;
      round_count = 0;
      foreach (window_medians[i]) window_medians[i] = '0;
      win_slot = 0;
      win_count = 0;
      win_total = '0;
      rounds_reported = '0;
      expected_reports.delete();
   endtask

   // Upper median: sorted entry at index ROUND_LEN/2.
   function automatic logic [SAMPLE_W-1:0] median_of_round();
      logic [SAMPLE_W-1:0] sorted [ROUND_LEN];
      logic [SAMPLE_W-1:0] key;
      int k;
      sorted = round_buf;
      for (int i = 1; i < ROUND_LEN; i++) begin
         key = sorted[i];
         k = i;
         while (k > 0 && sorted[k-1] > key) begin
            sorted[k] = sorted[k-1];
            k--;
         end
         sorted[k] = key;
      end
      return sorted[ROUND_LEN/2];
   endfunction

   // First test that holds wins: open, then short, then range.
   function automatic probe_state_type classify_level(input logic [VOLT_W-1:0] avg);
      if (avg > open_lvl) return PROBE_OPEN;
      if (avg < short_lvl) return PROBE_SHORT;
      if (avg > max_lvl || avg < min_lvl) return PROBE_OUT_OF_RANGE;
      return PROBE_OK;
   endfunction

   task automatic take_sample(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] med;
      logic [VOLT_W-1:0]   avg;
      probe_report_t       rpt;
      round_buf[round_count] = v;
      round_count++;
      if (round_count == ROUND_LEN) begin
         round_count = 0;
         med = median_of_round();
         win_total = win_total - window_medians[win_slot] + med;
         window_medians[win_slot] = med;
         win_slot = (win_slot + 1) % WIN_LEN;
         if (win_count < WIN_LEN) win_count++;
         avg = VOLT_W'(win_total / win_count);
         rpt.mean_voltage = avg;
         rpt.probe_state = classify_level(avg);
         rpt.round_number = rounds_reported;
         rounds_reported++;
         expected_reports.push_back(rpt);
      end
   endtask

   task automatic check_report();
      probe_report_t want;
      if (expected_reports.size() == 0) begin
         $error("probe report with no round pending: mean_voltage %0d, round_number %0d",
                rsp_mon.mean_voltage, rsp_mon.round_number);
         mismatches++;
      end else begin
         want = expected_reports.pop_front();
         if (rsp_mon.mean_voltage !== want.mean_voltage) begin
            $error("mean_voltage: expected %0d, actual %0d",
                   want.mean_voltage, rsp_mon.mean_voltage);
            mismatches++;
         end
         if (rsp_mon.probe_state !== want.probe_state) begin
            $error("probe_state: expected %0d, actual %0d",
                   want.probe_state, rsp_mon.probe_state);
            mismatches++;
         end
         if (rsp_mon.round_number !== want.round_number) begin
            $error("round_number: expected %0d, actual %0d",
                   want.round_number, rsp_mon.round_number);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_filter();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_report();
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_OPEN_THRESHOLD:  open_lvl = csr_wdata;
               CSR_SHORT_THRESHOLD: short_lvl = csr_wdata;
               CSR_VALID_MAX:       max_lvl = csr_wdata;
               CSR_VALID_MIN:       min_lvl = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) take_sample(req_mon.sample_voltage);
      end
      reports_pending = expected_reports.size();
   end

endmodule

### test/testbench.sv
module testbench import mmapc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF = 6;
   localparam int RESET_CYCLES = 8;
   localparam int WATCHDOG_CYCLES = 400000;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 80;
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

   typedef enum {ACCEPT_ALWAYS, ACCEPT_COIN, ACCEPT_PULSED, HOLD_OFF} rsp_pace_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            fail_count;
   int unsigned            pending;

   mmapc_req_if req_chan();
   mmapc_rsp_if rsp_chan();

   median_moving_average_probe_check dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   probe_report_checker report_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (fail_count),
      .reports_pending (pending)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   logic [CSR_DATA_W-1:0] open_set, short_set, max_set, min_set;
   int unsigned           samples_sent;
   int unsigned           burst_left;
   int unsigned           gap_len;
   bit                    no_gaps;
   int unsigned           target_level;
   int unsigned           target_spread;

   logic [SAMPLE_W-1:0] mixed_round [8] = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000,
                                            16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF};

   task automatic program_thresholds(input logic [CSR_DATA_W-1:0] o, input logic [CSR_DATA_W-1:0] s,
                                     input logic [CSR_DATA_W-1:0] mx,
                                     input logic [CSR_DATA_W-1:0] mn);
      open_set = o;
      short_set = s;
      max_set = mx;
      min_set = mn;
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_OPEN_THRESHOLD;
      csr_wdata <= o;
      @(negedge clock);
      csr_index <= CSR_SHORT_THRESHOLD;
      csr_wdata <= s;
      @(negedge clock);
      csr_index <= CSR_VALID_MAX;
      csr_wdata <= mx;
      @(negedge clock);
      csr_index <= CSR_VALID_MIN;
      csr_wdata <= mn;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] v);
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.sample_voltage <= v;
      do @(posedge clock); while (!req_chan.ready);
      samples_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         gap_len = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap_len > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap_len - 1) @(negedge clock);
         end
      end
   endtask

   // Hold the sender until every round has reported and the block has settled.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Steer rounds toward a threshold, a random level or a rail, so averages land on both sides of it.
   task automatic retarget();
      case ($urandom_range(0, 5))
         0: target_level = open_set;
         1: target_level = short_set;
         2: target_level = max_set;
         3: target_level = min_set;
         4: target_level = $urandom_range(0, SAMPLE_MAX);
         default: target_level = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      endcase
      target_spread = $urandom_range(0, 1) ? 0 : $urandom_range(1, 64);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom);
      v = int'(target_level) - int'(target_spread) + int'($urandom_range(0, 2 * target_spread));
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return SAMPLE_W'(v);
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] a, b, c, d;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_OPEN_THRESHOLD;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample_voltage = '0;
      samples_sent = 0;
      burst_left = 0;
      gap_len = 0;
      no_gaps = 1'b0;
      open_set = RESET_OPEN_THRESHOLD;
      short_set = RESET_SHORT_THRESHOLD;
      max_set = RESET_VALID_MAX;
      min_set = RESET_VALID_MIN;
      target_level = 0;
      target_spread = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero round, full-scale round, then a round of mixed bit patterns
      repeat (DEF_SAMPLES_PER_ROUND) send_sample('0);
      repeat (DEF_SAMPLES_PER_ROUND) send_sample(SAMPLE_W'(SAMPLE_MAX));
      foreach (mixed_round[i]) send_sample(mixed_round[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: program_thresholds('0, '0, '0, '0);
            1: program_thresholds('1, '1, '1, '1);
            2: program_thresholds(RESET_OPEN_THRESHOLD, RESET_SHORT_THRESHOLD,
                                  RESET_VALID_MAX, RESET_VALID_MIN);
            default: begin
               if (phase % 2 == 1) begin
                  b = $urandom_range(0, 4000);
                  d = $urandom_range(b, 16000);
                  c = $urandom_range(d, 50000);
                  a = $urandom_range(c, SAMPLE_MAX);
               end else begin
                  // overlapping thresholds in any order
                  a = $urandom;
                  b = $urandom;
                  c = $urandom;
                  d = $urandom;
               end
               program_thresholds(a, b, c, d);
            end
         endcase
         no_gaps = (phase % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (samples_sent % DEF_SAMPLES_PER_ROUND == 0 && $urandom_range(0, 2) == 0)
               retarget();
            if ($urandom_range(0, 199) == 0) wait_drained();
            send_sample(pick_sample());
         end
      end

      wait_drained();
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      rsp_pace_t   pace;
      int unsigned span;
      rsp_chan.ready = 1'b0;
      forever begin
         pace = rsp_pace_t'($urandom_range(0, 3));
         span = $urandom_range(8, 80);
         for (int unsigned n = 0; n < span; n++) begin
            @(negedge clock);
            case (pace)
               ACCEPT_ALWAYS: rsp_chan.ready <= 1'b1;
               ACCEPT_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               ACCEPT_PULSED: rsp_chan.ready <= (n % 5 == 0);
               default:       rsp_chan.ready <= 1'b0;
            endcase
         end
      end
   end

   initial begin
      repeat (WATCHDOG_CYCLES) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
